// ===== rtl/cumulative_damage_index_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef CUMULATIVE_DAMAGE_INDEX_MACROS_SVH
`define CUMULATIVE_DAMAGE_INDEX_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CDI_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdi check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CDI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdi check failed");

`endif

// ===== rtl/cdi_pkg.sv =====
package cdi_pkg;

    localparam int FIX_W      = 32;
    localparam int ENERGY_W   = 48;
    localparam int MUL_A_W    = 64;
    localparam int CHUNK_W    = 16;
    localparam int MUL_STEPS  = MUL_A_W / CHUNK_W;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int ACC_W      = 82;
    localparam int QUOT_W     = 50;
    localparam int PLASTIC_W  = ENERGY_W + 3;
    localparam int PTERM_W    = 51;
    localparam int CFG_IDX_W  = 1;

    localparam logic [FIX_W-1:0]   INV_ULT_RESET = 32'h0001_0000;
    localparam logic [QUOT_W-1:0]  ELASTIC_CAP   = QUOT_W'(1) << 49;
    localparam logic [PTERM_W-1:0] PTERM_CAP     = PTERM_W'(1) << 50;

    localparam logic [CFG_IDX_W-1:0] REG_INV_ULT      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_SCALE = 1'b1;

    typedef enum logic [1:0] {
        KIND_TRIAL        = 2'd0,
        KIND_COMMIT       = 2'd1,
        KIND_REVERT_LAST  = 2'd2,
        KIND_REVERT_START = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MUL_ENERGY  = 2'd0,
        MUL_FORCE   = 2'd1,
        MUL_PLASTIC = 2'd2,
        MUL_PEAK    = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic signed [FIX_W-1:0]    force_val;
        logic signed [FIX_W-1:0]    deform_val;
        logic signed [ENERGY_W-1:0] energy;
        logic [FIX_W-1:0]           peak;
        logic [FIX_W-1:0]           damage;
    } bank_t;

    typedef struct packed {
        logic     cap;
        logic     mul_load;
        mul_sel_t mul_sel;
        logic     mul_step;
        logic     te_save;
        logic     div_start;
        logic     pl_save;
        logic     pt_save;
        logic     dmg_save;
        logic     write;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  k_neg;
        logic  k_zero;
        logic  div_done;
        logic  out_free;
    } sts_t;

endpackage

// ===== rtl/cdi_if.sv =====
interface cdi_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] deformation;
    logic [31:0] force_req;
    logic [31:0] unloading_stiffness;

    modport source (
        output valid, kind, deformation, force_req, unloading_stiffness,
        input  ready
    );
    modport sink (
        input  valid, kind, deformation, force_req, unloading_stiffness,
        output ready
    );
endinterface

interface cdi_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] damage;
    logic [47:0] energy;
    logic [31:0] peak_deformation;
    logic        status;

    modport source (
        output valid, damage, energy, peak_deformation, status,
        input  ready
    );
    modport sink (
        input  valid, damage, energy, peak_deformation, status,
        output ready
    );
endinterface

// ===== rtl/cumulative_damage_index.sv =====
// channel   dir   handshake          payload
// item      in    valid / ready      kind, deformation, force_req, unloading_stiffness
// result    out   valid / ready      damage, energy, peak_deformation, status
// wr_*      in    wr_en              wr_index, wr_data (inv_ultimate_deformation, energy_scale)
//
// a trial with nonzero stiffness runs four products on one 16x32 multiply-accumulate unit,
// the two-bit-per-cycle divider (25 steps) and the control states between them; zero
// stiffness skips the divider, and an oversized quotient ends it without any steps
// commit, reverts and rejected trials skip the arithmetic and go straight to the write;
// the result waits in the write state while the output register is full; the next beat
// is taken in the cycle after the write
// reset clears all banks and sets the configuration registers to their reset values
module cumulative_damage_index import cdi_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    cdi_item_if.sink             item,
    cdi_result_if.source         result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [FIX_W-1:0]     wr_data
);

    cmd_t cmd;
    sts_t sts;

    cdi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    cdi_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .kind                (item.kind),
        .deformation         (item.deformation),
        .force_req           (item.force_req),
        .unloading_stiffness (item.unloading_stiffness),
        .wr_en               (wr_en),
        .wr_index            (wr_index),
        .wr_data             (wr_data),
        .res_valid           (result.valid),
        .res_ready           (result.ready),
        .damage              (result.damage),
        .energy              (result.energy),
        .peak_deformation    (result.peak_deformation),
        .status              (result.status)
    );

endmodule

// ===== rtl/cdi_div.sv =====
`include "cumulative_damage_index_macros.svh"

module cdi_div import cdi_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MUL_A_W-1:0]   dividend,
    input  logic [FIX_W-1:0]     divisor,
    output logic                 done,
    output logic                 sat,
    output logic [QUOT_W-1:0]    quotient
);

    localparam int BITS_PER_CYCLE = 2;
    localparam int STEPS          = QUOT_W / BITS_PER_CYCLE;
    localparam int CNT_W          = $clog2(STEPS);
    localparam int HI_W           = MUL_A_W - QUOT_W;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [FIX_W:0] div_step(
        input logic [FIX_W-1:0] rem,
        input logic             bit_in,
        input logic [FIX_W-1:0] dvs
    );
        logic [FIX_W:0] shifted;
        logic [FIX_W:0] diff;
        shifted = {rem, bit_in};
        diff    = shifted - {1'b0, dvs};
        if (diff[FIX_W])
            return {1'b0, shifted[FIX_W-1:0]};
        else
            return {1'b1, diff[FIX_W-1:0]};
    endfunction

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                sat_reg, sat_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [FIX_W-1:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0]   bits_reg, bits_next;
    logic [QUOT_W-1:0]   q_reg, q_next;
    logic [FIX_W:0]      step1, step2;
    logic                hi_over;

    // quotient too wide for QUOT_W bits when the top part already reaches the divisor
    assign hi_over = {{(FIX_W-HI_W){1'b0}}, dividend[MUL_A_W-1:QUOT_W]} >= divisor;

    assign step1 = div_step(rem_reg, bits_reg[QUOT_W-1], divisor);
    assign step2 = div_step(step1[FIX_W-1:0], bits_reg[QUOT_W-2], divisor);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        bits_next = bits_reg;
        q_next    = q_reg;
        if (start)
        begin
            sat_next  = hi_over;
            busy_next = !hi_over;
            done_next = hi_over;
            cnt_next  = '0;
            rem_next  = {{(FIX_W-HI_W){1'b0}}, dividend[MUL_A_W-1:QUOT_W]};
            bits_next = dividend[QUOT_W-1:0];
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = step2[FIX_W-1:0];
            bits_next = {bits_reg[QUOT_W-BITS_PER_CYCLE-1:0], {BITS_PER_CYCLE{1'b0}}};
            q_next    = {q_reg[QUOT_W-BITS_PER_CYCLE-1:0], step1[FIX_W], step2[FIX_W]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg  <= sat_next;
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        q_reg    <= q_next;
    end

    assign done     = done_reg;
    assign sat      = sat_reg;
    assign quotient = q_reg;

    `CDI_ASSERT_NEXT(a_start_runs, start, busy_reg || done_reg)

endmodule

// ===== rtl/cdi_ctrl.sv =====
`include "cumulative_damage_index_macros.svh"

module cdi_ctrl import cdi_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DISPATCH = 11'b000_0000_0010,
        S_LOAD     = 11'b000_0000_0100,
        S_MUL      = 11'b000_0000_1000,
        S_TE       = 11'b000_0001_0000,
        S_DIVGO    = 11'b000_0010_0000,
        S_DIV      = 11'b000_0100_0000,
        S_PLASTIC  = 11'b000_1000_0000,
        S_PTERM    = 11'b001_0000_0000,
        S_DMG      = 11'b010_0000_0000,
        S_WRITE    = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    mul_sel_t             op_reg, op_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        item_ready  = 1'b0;
        cmd         = '0;
        cmd.mul_sel = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.kind == KIND_TRIAL && !sts.k_neg)
                begin
                    op_next    = MUL_ENERGY;
                    state_next = S_LOAD;
                end
                else
                    state_next = S_WRITE;
            end
            S_LOAD:
            begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    unique case (op_reg)
                        MUL_ENERGY:  state_next = S_TE;
                        MUL_FORCE:   state_next = S_DIVGO;
                        MUL_PLASTIC: state_next = S_PTERM;
                        MUL_PEAK:    state_next = S_DMG;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_TE:
            begin
                cmd.te_save = 1'b1;
                op_next     = MUL_FORCE;
                state_next  = S_LOAD;
            end
            S_DIVGO:
            begin
                // zero stiffness has no elastic part
                if (sts.k_zero)
                    state_next = S_PLASTIC;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_PLASTIC;
            end
            S_PLASTIC:
            begin
                cmd.pl_save = 1'b1;
                op_next     = MUL_PLASTIC;
                state_next  = S_LOAD;
            end
            S_PTERM:
            begin
                cmd.pt_save = 1'b1;
                op_next     = MUL_PEAK;
                state_next  = S_LOAD;
            end
            S_DMG:
            begin
                cmd.dmg_save = 1'b1;
                state_next   = S_WRITE;
            end
            S_WRITE:
            begin
                if (sts.out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= MUL_ENERGY;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    `CDI_ASSERT_IMPLY(a_write_slot, cmd.write, sts.out_free)
    `CDI_ASSERT_IMPLY(a_div_positive, cmd.div_start, !sts.k_zero && !sts.k_neg)

endmodule

// ===== rtl/cdi_datapath.sv =====
`include "cumulative_damage_index_macros.svh"

module cdi_datapath import cdi_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic [1:0]                 kind,
    input  logic signed [FIX_W-1:0]    deformation,
    input  logic signed [FIX_W-1:0]    force_req,
    input  logic signed [FIX_W-1:0]    unloading_stiffness,
    input  logic                       wr_en,
    input  logic [CFG_IDX_W-1:0]       wr_index,
    input  logic [FIX_W-1:0]           wr_data,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [FIX_W-1:0]           damage,
    output logic signed [ENERGY_W-1:0] energy,
    output logic [FIX_W-1:0]           peak_deformation,
    output logic                       status
);

    // configuration
    logic [FIX_W-1:0] inv_reg, es_reg;

    // captured item
    kind_t                   kind_reg;
    logic signed [FIX_W-1:0] d_reg, f_reg, k_reg;

    // banks: trial, commit, last commit
    bank_t trial_reg, commit_reg, last_reg;
    bank_t trial_next, commit_next, last_next;

    // multiply-accumulate, one 16-bit chunk of a per step, top chunk first
    logic [MUL_A_W-1:0] a_reg;
    logic [FIX_W-1:0]   b_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [MUL_A_W-1:0] a_sel;
    logic [FIX_W-1:0]   b_sel;
    logic [CHUNK_W+FIX_W-1:0] partial;

    // intermediate results
    logic signed [ENERGY_W-1:0]  te_reg, te_next;
    logic signed [PLASTIC_W-1:0] plastic_reg, plastic_next;
    logic [PTERM_W-1:0]          pterm_reg, pterm_next;
    logic [FIX_W-1:0]            dmg_reg, dmg_next;

    // output register
    logic                       res_valid_reg;
    logic [FIX_W-1:0]           res_damage_reg;
    logic signed [ENERGY_W-1:0] res_energy_reg;
    logic [FIX_W-1:0]           res_peak_reg;
    logic                       res_status_reg;
    logic                       status_next;

    logic signed [FIX_W:0]     s_sum, dd_diff, s_abs, dd_abs;
    logic [FIX_W:0]            s_mag;
    logic [FIX_W-1:0]          dd_mag, f_mag, d_mag, peak_new;
    logic signed [PLASTIC_W-1:0] p_abs;
    logic [QUOT_W-1:0]         p_mag;
    logic                      inc_neg;
    logic [ENERGY_W-2:0]       inc;
    logic signed [ENERGY_W+1:0] te_sum;
    logic [QUOT_W-1:0]         quot, elastic;
    logic                      div_done, div_sat;
    logic [ACC_W-17:0]         prod_sh;
    logic [ENERGY_W-1:0]       dterm;
    logic signed [ENERGY_W+4:0] dmg_sum;
    logic [FIX_W-1:0]          dmg_clamp;

    cdi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg[MUL_A_W-1:0]),
        .divisor  ({k_reg[FIX_W-2:0], 1'b0}),
        .done     (div_done),
        .sat      (div_sat),
        .quotient (quot)
    );

    // trapezoid terms against the committed bank
    assign s_sum   = {f_reg[FIX_W-1], f_reg} + {commit_reg.force_val[FIX_W-1], commit_reg.force_val};
    assign dd_diff = {d_reg[FIX_W-1], d_reg}
                   - {commit_reg.deform_val[FIX_W-1], commit_reg.deform_val};
    assign s_abs   = s_sum[FIX_W] ? -s_sum : s_sum;
    assign dd_abs  = dd_diff[FIX_W] ? -dd_diff : dd_diff;
    assign s_mag   = s_abs;
    assign dd_mag  = dd_abs[FIX_W-1:0];
    assign f_mag   = f_reg[FIX_W-1] ? -f_reg : f_reg;
    assign d_mag   = d_reg[FIX_W-1] ? -d_reg : d_reg;
    assign peak_new = (d_mag > commit_reg.peak) ? d_mag : commit_reg.peak;
    assign p_abs   = plastic_reg[PLASTIC_W-1] ? -plastic_reg : plastic_reg;
    assign p_mag   = p_abs[QUOT_W-1:0];

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_ENERGY:
            begin
                a_sel = MUL_A_W'(s_mag);
                b_sel = dd_mag;
            end
            MUL_FORCE:
            begin
                a_sel = MUL_A_W'(f_mag);
                b_sel = f_mag;
            end
            MUL_PLASTIC:
            begin
                a_sel = MUL_A_W'(p_mag);
                b_sel = es_reg;
            end
            default:
            begin
                a_sel = MUL_A_W'(peak_new);
                b_sel = inv_reg;
            end
        endcase
    end

    assign partial = a_reg[MUL_A_W-1:MUL_A_W-CHUNK_W] * b_reg;

    // energy: committed energy plus half the trapezoid, saturated to 48 bits
    assign inc_neg = s_sum[FIX_W] ^ dd_diff[FIX_W];
    assign inc     = acc_reg[MUL_A_W-1:17];
    assign te_sum  = {{2{commit_reg.energy[ENERGY_W-1]}}, commit_reg.energy}
                   + (inc_neg ? -{3'b000, inc} : {3'b000, inc});

    always_comb
    begin
        if (!te_sum[ENERGY_W+1] && te_sum[ENERGY_W:ENERGY_W-1] != 2'b00)
            te_next = {1'b0, {(ENERGY_W-1){1'b1}}};
        else if (te_sum[ENERGY_W+1] && te_sum[ENERGY_W:ENERGY_W-1] != 2'b11)
            te_next = {1'b1, {(ENERGY_W-1){1'b0}}};
        else
            te_next = te_sum[ENERGY_W-1:0];
    end

    // elastic energy from the divider, capped
    assign elastic = (div_sat || quot > ELASTIC_CAP) ? ELASTIC_CAP : quot;

    always_comb
    begin
        if (sts.k_zero)
            plastic_next = {{3{te_reg[ENERGY_W-1]}}, te_reg};
        else
            plastic_next = {{3{te_reg[ENERGY_W-1]}}, te_reg} - {1'b0, elastic};
    end

    assign prod_sh    = acc_reg[ACC_W-1:16];
    assign pterm_next = (prod_sh > (ACC_W-16)'(PTERM_CAP)) ? PTERM_CAP : prod_sh[PTERM_W-1:0];

    // damage: deformation term plus signed energy term, clamped, not below commit
    assign dterm   = acc_reg[MUL_A_W-1:16];
    assign dmg_sum = {5'b0, dterm}
                   + (plastic_reg[PLASTIC_W-1] ? -{2'b00, pterm_reg} : {2'b00, pterm_reg});

    always_comb
    begin
        if (dmg_sum[ENERGY_W+4])
            dmg_clamp = '0;
        else if (dmg_sum[ENERGY_W+3:FIX_W] != '0)
            dmg_clamp = '1;
        else
            dmg_clamp = dmg_sum[FIX_W-1:0];
        dmg_next = (dmg_clamp < commit_reg.damage) ? commit_reg.damage : dmg_clamp;
    end

    // bank update on the write beat
    always_comb
    begin
        trial_next  = trial_reg;
        commit_next = commit_reg;
        last_next   = last_reg;
        status_next = 1'b0;
        unique case (kind_reg)
            KIND_TRIAL:
            begin
                if (k_reg[FIX_W-1])
                    status_next = 1'b1;
                else
                    trial_next = '{force_val: f_reg, deform_val: d_reg, energy: te_reg,
                                   peak: peak_new, damage: dmg_reg};
            end
            KIND_COMMIT:
            begin
                last_next   = commit_reg;
                commit_next = trial_reg;
            end
            KIND_REVERT_LAST:
                commit_next = last_reg;
            KIND_REVERT_START:
            begin
                trial_next  = '0;
                commit_next = '0;
                last_next   = '0;
            end
            default: status_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= INV_ULT_RESET;
            es_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_INV_ULT:      inv_reg <= wr_data;
                REG_ENERGY_SCALE: es_reg  <= wr_data;
                default:          inv_reg <= inv_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trial_reg     <= '0;
            commit_reg    <= '0;
            last_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                trial_reg  <= trial_next;
                commit_reg <= commit_next;
                last_reg   <= last_next;
            end
            if (cmd.write)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            kind_reg <= kind_t'(kind);
            d_reg    <= deformation;
            f_reg    <= force_req;
            k_reg    <= unloading_stiffness;
        end
        if (cmd.mul_load)
        begin
            a_reg   <= a_sel;
            b_reg   <= b_sel;
            acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            a_reg   <= {a_reg[MUL_A_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            acc_reg <= {acc_reg[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(partial);
        end
        if (cmd.te_save)
            te_reg <= te_next;
        if (cmd.pl_save)
            plastic_reg <= plastic_next;
        if (cmd.pt_save)
            pterm_reg <= pterm_next;
        if (cmd.dmg_save)
            dmg_reg <= dmg_next;
        if (cmd.write)
        begin
            res_damage_reg <= trial_next.damage;
            res_energy_reg <= trial_next.energy;
            res_peak_reg   <= trial_next.peak;
            res_status_reg <= status_next;
        end
    end

    assign sts.kind     = kind_reg;
    assign sts.k_neg    = k_reg[FIX_W-1];
    assign sts.k_zero   = (k_reg == '0);
    assign sts.div_done = div_done;
    assign sts.out_free = !res_valid_reg || res_ready;

    assign res_valid        = res_valid_reg;
    assign damage           = res_damage_reg;
    assign energy           = res_energy_reg;
    assign peak_deformation = res_peak_reg;
    assign status           = res_status_reg;

    `CDI_ASSERT_NEXT(a_reject_holds, cmd.write && kind_reg == KIND_TRIAL && k_reg[FIX_W-1], trial_reg == $past(trial_reg))
    `CDI_ASSERT_NEXT(a_damage_floor, cmd.write && kind_reg == KIND_TRIAL && !k_reg[FIX_W-1], trial_reg.damage >= commit_reg.damage)
    `CDI_ASSERT_IMPLY(a_valid_source, $rose(res_valid_reg), $past(cmd.write))

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import cdi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [31:0] FIX_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] FIX_MIN = 32'h8000_0000;
    localparam logic [31:0] FIX_ONE = 32'h0001_0000;

    localparam longint NRG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint NRG_MIN = -64'sh0000_8000_0000_0000;
    localparam longint DMG_MAX = 64'sh0000_0000_FFFF_FFFF;
    localparam logic [63:0] ELASTIC_LIMIT = 64'd1 << 49;
    localparam logic [63:0] TERM_LIMIT = 64'd1 << 50;

    localparam int TRIAL_SLOT = 0;
    localparam int COMMIT_SLOT = 1;
    localparam int LAST_SLOT = 2;

    typedef struct packed {
        logic [31:0] damage;
        logic [47:0] energy;
        logic [31:0] peak;
        logic        status;
    } dmg_report_t;

    typedef struct {
        logic signed [31:0] frc;
        logic signed [31:0] dfm;
        logic signed [47:0] nrg;
        logic [31:0]        pk;
        logic [31:0]        dmg;
    } snap_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [FIX_W-1:0] wr_data;

    cdi_item_if item_ch();
    cdi_result_if result_ch();

    cumulative_damage_index u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // load history: trial, committed, previously committed
    snap_t history[3];
    logic [31:0] inv_ult_q16;
    logic [31:0] energy_scale_q16;

    dmg_report_t report_q[$];
    int fail_count = 0;
    bit source_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    int hold_asks = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("cumulative_damage_index: mismatch");
        $finish;
    end

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < 3; i++)
            history[i] = '{default: '0};
    endfunction

    function automatic dmg_report_t step_damage_model(input kind_t kd,
                                                      input logic [31:0] d_raw,
                                                      input logic [31:0] f_raw,
                                                      input logic [31:0] k_raw);
        dmg_report_t rep;
        longint d, f, s, dd, te, plastic, dmg;
        logic [63:0] inc, el, fm, peak, pterm, dterm;
        logic [127:0] wide;
        rep.status = 1'b0;
        case (kd)
            KIND_TRIAL:
            begin
                if (k_raw[31])
                    rep.status = 1'b1;
                else
                begin
                    d = longint'(signed'(d_raw));
                    f = longint'(signed'(f_raw));
                    s = f + longint'(history[COMMIT_SLOT].frc);
                    dd = d - longint'(history[COMMIT_SLOT].dfm);
                    // trapezoid area, half and rescale folded into one shift
                    inc = (magnitude(s) * magnitude(dd)) >> 17;
                    te = longint'(history[COMMIT_SLOT].nrg)
                         + (((s < 0) != (dd < 0)) ? -longint'(inc) : longint'(inc));
                    if (te > NRG_MAX)
                        te = NRG_MAX;
                    if (te < NRG_MIN)
                        te = NRG_MIN;
                    plastic = te;
                    if (k_raw != 32'd0)
                    begin
                        fm = magnitude(f);
                        el = (fm * fm) / ({32'd0, k_raw} << 1);
                        if (el > ELASTIC_LIMIT)
                            el = ELASTIC_LIMIT;
                        plastic = te - longint'(el);
                    end
                    peak = magnitude(d);
                    if (peak < {32'd0, history[COMMIT_SLOT].pk})
                        peak = {32'd0, history[COMMIT_SLOT].pk};
                    wide = ({64'd0, magnitude(plastic)} * {96'd0, energy_scale_q16}) >> 16;
                    pterm = (wide > {64'd0, TERM_LIMIT}) ? TERM_LIMIT : wide[63:0];
                    dterm = (peak * {32'd0, inv_ult_q16}) >> 16;
                    dmg = longint'(dterm) + ((plastic < 0) ? -longint'(pterm) : longint'(pterm));
                    if (dmg < 0)
                        dmg = 0;
                    if (dmg > DMG_MAX)
                        dmg = DMG_MAX;
                    if (dmg[31:0] < history[COMMIT_SLOT].dmg)
                        dmg = longint'({32'd0, history[COMMIT_SLOT].dmg});
                    history[TRIAL_SLOT].frc = f_raw;
                    history[TRIAL_SLOT].dfm = d_raw;
                    history[TRIAL_SLOT].nrg = te[47:0];
                    history[TRIAL_SLOT].pk = peak[31:0];
                    history[TRIAL_SLOT].dmg = dmg[31:0];
                end
            end
            KIND_COMMIT:
            begin
                history[LAST_SLOT] = history[COMMIT_SLOT];
                history[COMMIT_SLOT] = history[TRIAL_SLOT];
            end
            KIND_REVERT_LAST:
                history[COMMIT_SLOT] = history[LAST_SLOT];
            default:
                clear_history();
        endcase
        rep.damage = history[TRIAL_SLOT].dmg;
        rep.energy = history[TRIAL_SLOT].nrg;
        rep.peak = history[TRIAL_SLOT].pk;
        return rep;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // result side: checks every beat and throttles ready
    initial
    begin : result_sink
        dmg_report_t want;
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (report_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual damage %h",
                             $time, result_ch.damage);
                    fail_count++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("damage", want.damage, result_ch.damage);
                    check_field("energy", want.energy, result_ch.energy);
                    check_field("peak_deformation", want.peak, result_ch.peak_deformation);
                    check_field("status", want.status, result_ch.status);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_asks != holds_served)
            begin
                holds_served = hold_asks;
                hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= !(sink_gaps && $urandom_range(99) < 10);
        end
    end

    task automatic send_item(input kind_t kd, input logic [31:0] dfm, input logic [31:0] frc,
                             input logic [31:0] stf);
        if (source_gaps)
            while ($urandom_range(99) < 10)
            begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
            end
        item_ch.valid <= 1'b1;
        item_ch.kind <= kd;
        item_ch.deformation <= dfm;
        item_ch.force_req <= frc;
        item_ch.unloading_stiffness <= stf;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        report_q.push_back(step_damage_model(kd, dfm, frc, stf));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        item_ch.valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_INV_ULT)
            inv_ult_q16 = val;
        else
            energy_scale_q16 = val;
    endtask

    function automatic logic [31:0] pick_fix();
        case ($urandom_range(7))
            0: return FIX_MIN;
            1: return FIX_MAX;
            2: return 32'd0;
            3, 4: return 32'($urandom_range(32'h0008_0000) - 32'h0004_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_stiffness();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return $urandom() | 32'h8000_0000;
            2: return FIX_MAX;
            3: return 32'd1;
            4, 5: return $urandom_range(32'h0010_0000, 1);
            default: return $urandom() & 32'h7FFF_FFFF;
        endcase
    endfunction

    // mostly trials and commits, with reverts mixed in
    task automatic send_random_item();
        int pick;
        kind_t kd;
        pick = $urandom_range(99);
        if (pick < 55)
            kd = KIND_TRIAL;
        else if (pick < 85)
            kd = KIND_COMMIT;
        else if (pick < 95)
            kd = KIND_REVERT_LAST;
        else
            kd = KIND_REVERT_START;
        send_item(kd, pick_fix(), pick_fix(), pick_stiffness());
    endtask

    task automatic test_directed();
        send_item(KIND_TRIAL, FIX_ONE, FIX_ONE, 32'd0);
        write_reg(REG_ENERGY_SCALE, FIX_ONE);
        send_item(KIND_TRIAL, 32'd0, 32'd0, 32'd0);
        // elastic energy hits its cap, damage floors at zero
        send_item(KIND_TRIAL, FIX_MAX, FIX_MAX, 32'd1);
        send_item(KIND_TRIAL, 32'd5, 32'd5, 32'hFFFF_FFFF);
        send_item(KIND_TRIAL, FIX_MIN, FIX_MIN, FIX_MAX);
        send_item(KIND_REVERT_START, FIX_MAX, FIX_MAX, FIX_MAX);
        // closed loop drives the energy into positive saturation
        send_item(KIND_TRIAL, FIX_MAX, FIX_MAX, 32'd0);
        send_item(KIND_COMMIT, 32'd0, 32'd0, 32'd0);
        send_item(KIND_TRIAL, FIX_MAX, FIX_MIN, 32'd0);
        send_item(KIND_COMMIT, 32'd0, 32'd0, 32'd0);
        send_item(KIND_TRIAL, FIX_MIN, FIX_MIN, 32'd0);
        send_item(KIND_COMMIT, 32'd0, 32'd0, 32'd0);
        send_item(KIND_REVERT_LAST, 32'd0, 32'd0, 32'd0);
        send_item(KIND_TRIAL, 32'd0, 32'd0, FIX_ONE);
        send_item(KIND_REVERT_START, 32'd0, 32'd0, 32'd0);
        // reverse loop into negative saturation, damage held at committed value
        send_item(KIND_TRIAL, FIX_MIN, FIX_MAX, 32'd0);
        send_item(KIND_COMMIT, 32'd0, 32'd0, 32'd0);
        send_item(KIND_TRIAL, FIX_MIN, FIX_MIN, 32'd0);
        send_item(KIND_COMMIT, 32'd0, 32'd0, 32'd0);
        send_item(KIND_TRIAL, FIX_MAX, FIX_MIN, 32'd0);
        send_item(KIND_COMMIT, 32'd0, 32'd0, 32'd0);
        send_item(KIND_TRIAL, 32'd1, 32'h7FFF_0000, 32'd1);
        send_item(KIND_REVERT_LAST, 32'd0, 32'd0, 32'd0);
        send_item(KIND_REVERT_START, 32'd0, 32'd0, 32'd0);
    endtask

    task automatic test_register_sweep();
        logic [31:0] inv_set[5];
        logic [31:0] scale_set[5];
        inv_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, FIX_ONE, $urandom()};
        scale_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, $urandom()};
        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_INV_ULT, inv_set[p]);
            write_reg(REG_ENERGY_SCALE, scale_set[p]);
            repeat (30) send_random_item();
        end
    endtask

    task automatic test_backpressure();
        hold_asks++;
        repeat (20) send_random_item();
    endtask

    task automatic test_random_traffic(input int count);
        write_reg(REG_INV_ULT, $urandom_range(32'h0004_0000));
        write_reg(REG_ENERGY_SCALE, $urandom_range(32'h0000_1000));
        repeat (count) send_random_item();
    endtask

    task automatic test_steady_stream(input int count);
        source_gaps = 1'b0;
        sink_gaps = 1'b0;
        repeat (count) send_random_item();
        source_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    initial
    begin : stimulus
        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.kind <= KIND_TRIAL;
        item_ch.deformation <= '0;
        item_ch.force_req <= '0;
        item_ch.unloading_stiffness <= '0;
        wr_en <= 1'b0;
        wr_index <= REG_INV_ULT;
        wr_data <= '0;
        inv_ult_q16 = INV_ULT_RESET;
        energy_scale_q16 = '0;
        clear_history();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_sweep();
        test_backpressure();
        test_random_traffic(1250);
        test_steady_stream(300);

        item_ch.valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && report_q.size() == 0)
            $display("cumulative_damage_index: match");
        else
            $display("cumulative_damage_index: mismatch");
        $finish;
    end

endmodule
